### rtl/a85d_pkg.sv
// ----------------------------------------------------------------------------
// a85d_pkg
// Shared types, character codes and base-85 weights for the Ascii85 stream
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package a85d_pkg;

    // Character codes
    localparam logic [7:0] CH_BANG  = 8'h21;   // '!' lowest digit
    localparam logic [7:0] CH_U     = 8'h75;   // 'u' highest digit
    localparam logic [7:0] CH_Z     = 8'h7A;   // 'z' four zero bytes
    localparam logic [7:0] CH_Y     = 8'h79;   // 'y' four space bytes
    localparam logic [7:0] CH_LT    = 8'h3C;   // '<'
    localparam logic [7:0] CH_TILDE = 8'h7E;   // '~'
    localparam logic [7:0] CH_GT    = 8'h3E;   // '>'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [31:0] SPACE_WORD = 32'h2020_2020;

    // Powers of 85 used as digit weights
    localparam int unsigned W85_4 = 85 * 85 * 85 * 85;
    localparam int unsigned W85_3 = 85 * 85 * 85;
    localparam int unsigned W85_2 = 85 * 85;
    localparam int unsigned W85_1 = 85;
    localparam int WEIGHT_W = 26;

    // Number of result slots per input item
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = 2;
    localparam int COUNT_W     = 3;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_REQUIRE_DELIM = 1'b0;
    localparam logic REG_IGNORE_INVALID = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_MISSING_LT  = 3'd1,
        ERR_TILDE_NO_GT = 3'd2,
        ERR_MISSING_GT  = 3'd3,
        ERR_INVALID     = 3'd4
    } err_code_t;

    // Decoder phase, one-hot
    typedef enum logic [4:0] {
        PH_START     = 5'b00001,
        PH_SAW_LT    = 5'b00010,
        PH_BODY      = 5'b00100,
        PH_SAW_TILDE = 5'b01000,
        PH_DRAIN     = 5'b10000
    } phase_t;

    // One result slot
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        err_code_t  error_code;
    } result_t;

    // Weight of the digit at a given group position (0 = most significant)
    function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [2:0] pos);
        logic [WEIGHT_W-1:0] w;
        begin
            case (pos)
                3'd0:    w = WEIGHT_W'(W85_4);
                3'd1:    w = WEIGHT_W'(W85_3);
                3'd2:    w = WEIGHT_W'(W85_2);
                3'd3:    w = WEIGHT_W'(W85_1);
                default: w = WEIGHT_W'(1);
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/ascii85_stream_decoder.sv
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Ascii85 decoder: one character or end-of-input marker per request in, one
// decoded byte, finish or error result per request out.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Contents
//  -------   ---  ---------          --------
//  s_*       in   s_tvalid/s_tready  tdata = in_char, tlast = end_of_input
//  m_*       out  m_tvalid/m_tready  tdata = out_byte, error_code;
//                                    tuser = out_kind; tlast = last
//  APB       in   psel/penable       0x0 require_delimiters, 0x4 ignore_invalid
//
//  An input request is decoded in the cycle it is accepted and its results
//  (up to four) land in the output slot bank; one result leaves per cycle
//  while m_tready is high. The input is held until the last result of an
//  item leaves, so items with at most one result go through at one per
//  cycle while m_tready is high. Reset is asynchronous and needs no clearing
//  pass; the input stalls only while results of the previous item still wait.
//
`default_nettype none

module ascii85_stream_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_char
    input  wire logic        s_tlast,    // end_of_input
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [7:0] out_byte, [10:8] error_code, zero above
    output logic [1:0]       m_tuser,    // [1:0] out_kind
    output logic             m_tlast,    // last
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [a85d_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [a85d_pkg::APB_DATA_W-1:0] pwdata,
    output logic [a85d_pkg::APB_DATA_W-1:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic require_delim_reg;
    logic ignore_invalid_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_delim_reg  <= 1'b0;
            ignore_invalid_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == a85d_pkg::REG_REQUIRE_DELIM)
                require_delim_reg <= pwdata[0];
            else
                ignore_invalid_reg <= pwdata[0];
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == a85d_pkg::REG_REQUIRE_DELIM)
            prdata[0] = require_delim_reg;
        else
            prdata[0] = ignore_invalid_reg;
    end

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    a85d_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       dcount_reg, dcount_next;
    logic [31:0]      acc_reg, acc_next;

    // Output slot bank
    a85d_pkg::result_t slot_reg [a85d_pkg::MAX_RESULTS];
    logic [a85d_pkg::COUNT_W-1:0] count_reg;
    logic [a85d_pkg::SLOT_W-1:0]  rd_reg;

    // Results of the item being accepted
    a85d_pkg::result_t res [a85d_pkg::MAX_RESULTS];
    logic [a85d_pkg::COUNT_W-1:0] res_count;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic pop, pop_last, accept;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign pop_last = pop && ({1'b0, rd_reg} == count_reg - 1'b1);
    assign s_tready = (count_reg == '0) || pop_last;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [7:0]                       ch;
    logic                             eoi;
    logic                             is_space;
    logic                             is_digit;
    logic [7:0]                       ch_off;
    logic [6:0]                       digit_val;
    logic [2:0]                       dpos;
    logic [a85d_pkg::WEIGHT_W-1:0]    wgt;
    logic [31:0]                      prod;
    logic [31:0]                      acc_sum;
    logic [31:0]                      fin_word;
    logic [2:0]                       fin_pos;

    assign ch       = s_tdata;
    assign eoi      = s_tlast;
    assign is_space = (ch == a85d_pkg::CH_SPACE) ||
                      ((ch >= a85d_pkg::CH_TAB) && (ch <= a85d_pkg::CH_CR));
    assign is_digit = (ch >= a85d_pkg::CH_BANG) && (ch <= a85d_pkg::CH_U);
    assign ch_off   = ch - a85d_pkg::CH_BANG;
    assign digit_val = ch_off[6:0];
    assign dpos     = (dcount_reg > 3'd4) ? 3'd0 : dcount_reg;
    assign wgt      = a85d_pkg::digit_weight(dpos);
    // Product wraps at 32 bits along with the accumulator
    assign prod     = 32'(digit_val) * 32'(wgt);
    assign acc_sum  = acc_reg + prod;

    // Round a partial group up by the weight of its last received digit
    assign fin_pos  = dcount_reg - 3'd1;
    assign fin_word = acc_reg + 32'(a85d_pkg::digit_weight(fin_pos));

    // ------------------------------------------------------------------
    // Decode one item
    // ------------------------------------------------------------------
    always_comb
    begin
        a85d_pkg::phase_t eff_phase;
        logic [2:0]       fcnt;

        phase_next  = phase_reg;
        dcount_next = dcount_reg;
        acc_next    = acc_reg;
        res_count   = '0;
        fcnt        = '0;
        for (int k = 0; k < a85d_pkg::MAX_RESULTS; k++)
        begin
            res[k].out_byte   = '0;
            res[k].out_kind   = a85d_pkg::KIND_DATA;
            res[k].error_code = a85d_pkg::ERR_NONE;
        end

        eff_phase = phase_reg;
        if ((phase_reg == a85d_pkg::PH_START) && !require_delim_reg)
            eff_phase = a85d_pkg::PH_BODY;

        if (phase_reg == a85d_pkg::PH_DRAIN)
        begin
            // Drop everything up to end of input, then restart
            if (eoi)
            begin
                phase_next  = a85d_pkg::PH_START;
                dcount_next = '0;
                acc_next    = '0;
            end
        end
        else if (!eoi && is_space)
        begin
            // Skip whitespace
        end
        else
        begin
            phase_next = eff_phase;
            unique case (eff_phase)
                a85d_pkg::PH_START:
                begin
                    if (eoi)
                    begin
                        res[0].out_kind   = a85d_pkg::KIND_ERR;
                        res[0].error_code = a85d_pkg::ERR_MISSING_LT;
                        res_count   = 3'd1;
                        phase_next  = a85d_pkg::PH_START;
                        dcount_next = '0;
                        acc_next    = '0;
                    end
                    else if (ch == a85d_pkg::CH_LT)
                        phase_next = a85d_pkg::PH_SAW_LT;
                end

                a85d_pkg::PH_SAW_LT:
                begin
                    if (eoi)
                    begin
                        res[0].out_kind   = a85d_pkg::KIND_ERR;
                        res[0].error_code = a85d_pkg::ERR_MISSING_LT;
                        res_count   = 3'd1;
                        phase_next  = a85d_pkg::PH_START;
                        dcount_next = '0;
                        acc_next    = '0;
                    end
                    else if (ch == a85d_pkg::CH_TILDE)
                        phase_next = a85d_pkg::PH_BODY;
                    else if (ch != a85d_pkg::CH_LT)
                        phase_next = a85d_pkg::PH_START;
                end

                a85d_pkg::PH_BODY:
                begin
                    if (eoi)
                    begin
                        if (require_delim_reg)
                        begin
                            res[0].out_kind   = a85d_pkg::KIND_ERR;
                            res[0].error_code = a85d_pkg::ERR_MISSING_GT;
                            res_count = 3'd1;
                        end
                        else
                            fcnt = 3'd1;
                        phase_next  = a85d_pkg::PH_START;
                        dcount_next = '0;
                        acc_next    = '0;
                    end
                    else if ((ch == a85d_pkg::CH_Z) && (dcount_reg == '0))
                    begin
                        res_count = 3'd4;
                    end
                    else if ((ch == a85d_pkg::CH_Y) && (dcount_reg == '0))
                    begin
                        for (int k = 0; k < a85d_pkg::MAX_RESULTS; k++)
                            res[k].out_byte = a85d_pkg::SPACE_WORD[31-8*k -: 8];
                        res_count = 3'd4;
                    end
                    else if ((ch == a85d_pkg::CH_TILDE) && require_delim_reg)
                    begin
                        phase_next = a85d_pkg::PH_SAW_TILDE;
                    end
                    else if (!is_digit)
                    begin
                        if (!ignore_invalid_reg)
                        begin
                            res[0].out_kind   = a85d_pkg::KIND_ERR;
                            res[0].error_code = a85d_pkg::ERR_INVALID;
                            res_count   = 3'd1;
                            phase_next  = a85d_pkg::PH_DRAIN;
                            dcount_next = '0;
                            acc_next    = '0;
                        end
                    end
                    else if (dpos == 3'd4)
                    begin
                        // Fifth digit completes the group
                        for (int k = 0; k < a85d_pkg::MAX_RESULTS; k++)
                            res[k].out_byte = acc_sum[31-8*k -: 8];
                        res_count   = 3'd4;
                        dcount_next = '0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        acc_next    = acc_sum;
                        dcount_next = dpos + 3'd1;
                    end
                end

                a85d_pkg::PH_SAW_TILDE:
                begin
                    if (!eoi && (ch == a85d_pkg::CH_GT))
                    begin
                        fcnt        = 3'd1;
                        phase_next  = a85d_pkg::PH_DRAIN;
                        dcount_next = '0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        res[0].out_kind   = a85d_pkg::KIND_ERR;
                        res[0].error_code = a85d_pkg::ERR_TILDE_NO_GT;
                        res_count   = 3'd1;
                        phase_next  = eoi ? a85d_pkg::PH_START : a85d_pkg::PH_DRAIN;
                        dcount_next = '0;
                        acc_next    = '0;
                    end
                end

                default:
                begin
                    phase_next  = a85d_pkg::PH_START;
                    dcount_next = '0;
                    acc_next    = '0;
                end
            endcase

            // Flush a partial group, then mark the stream finished
            if (fcnt != '0)
            begin
                for (int k = 0; k < a85d_pkg::MAX_RESULTS; k++)
                    res[k].out_byte = fin_word[31-8*k -: 8];
                if ((dcount_reg == '0) || (dcount_reg > 3'd4))
                begin
                    res_count = 3'd1;
                    res[0].out_byte = '0;
                    res[0].out_kind = a85d_pkg::KIND_DONE;
                end
                else
                begin
                    res_count = dcount_reg;
                    res[fin_pos[a85d_pkg::SLOT_W-1:0]].out_byte = '0;
                    res[fin_pos[a85d_pkg::SLOT_W-1:0]].out_kind = a85d_pkg::KIND_DONE;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Advance decoder state on accept
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= a85d_pkg::PH_START;
            dcount_reg <= '0;
            acc_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            dcount_reg <= dcount_next;
            acc_reg    <= acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Output slot bank: load on accept, drain one slot per request
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= '0;
        end
        else if (accept)
        begin
            count_reg <= res_count;
            rd_reg    <= '0;
        end
        else if (pop)
        begin
            if (pop_last)
            begin
                count_reg <= '0;
                rd_reg    <= '0;
            end
            else
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < a85d_pkg::MAX_RESULTS; k++)
                slot_reg[k] <= res[k];
        end
    end

    // Present the current slot
    a85d_pkg::result_t cur;
    assign cur     = slot_reg[rd_reg];
    assign m_tdata = {5'b0, cur.error_code, cur.out_byte};
    assign m_tuser = cur.out_kind;
    assign m_tlast = ({1'b0, rd_reg} == count_reg - 1'b1);

endmodule

`default_nettype wire

### rtl/a85d_checker.sv
// ----------------------------------------------------------------------------
// a85d_checker
// Port-level checks for the Ascii85 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module a85d_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled result changed");

    // Input stalls only while results still wait
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

    // Errors carry a code, no byte, and end the item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == a85d_pkg::KIND_ERR) |->
        (m_tdata[7:0] == 8'd0) && (m_tdata[10:8] != a85d_pkg::ERR_NONE) && m_tlast)
    else $error("malformed error result");

    // Data and finish results carry no error code; finish ends the item
    a_ok_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != a85d_pkg::KIND_ERR) |->
        (m_tuser != 2'd3) && (m_tdata[10:8] == a85d_pkg::ERR_NONE) &&
        ((m_tuser != a85d_pkg::KIND_DONE) || m_tlast))
    else $error("malformed data or finish result");

endmodule

bind ascii85_stream_decoder a85d_checker u_a85d_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/ascii85_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii85_stream_decoder_tb
// Self-checking bench for the Ascii85 stream decoder. A queue of character
// requests feeds the input stream. An in-bench decoder predicts every data,
// finish and error result, and the output stream is checked against it.
// Both stream sides stall at random. Every register setting is exercised
// through the APB port.
// ----------------------------------------------------------------------------

module ascii85_stream_decoder_tb;

    import a85d_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 160;
    localparam int ITEMS_PER_SETTING = 40;
    localparam int REPORT_LINES = 20;

    localparam logic [APB_ADDR_W-1:0] ADDR_REQUIRE = {REG_REQUIRE_DELIM, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_IGNORE  = {REG_IGNORE_INVALID, 2'b00};

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } char_req_t;

    typedef struct {
        logic [7:0] data;
        kind_t      kind;
        err_code_t  code;
        logic       last;
    } decoded_t;

    // DUT signals
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Request and result bookkeeping
    char_req_t char_queue[$];
    decoded_t  decoded_due[$];
    decoded_t  due_now;
    int        pushed_count = 0;
    int        accepted_count = 0;
    int        results_seen = 0;
    int        errors_seen = 0;
    int        mismatches = 0;
    int        cycle_count = 0;

    // Decoder shadow state and register copies
    phase_t      dec_phase = PH_START;
    int          dec_count = 0;
    logic [31:0] dec_acc = '0;
    logic        cfg_require = 1'b0;
    logic        cfg_ignore = 1'b0;

    // Idle pattern control
    int   tx_gap = 0;
    int   rx_gap = 0;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    logic want_long_hold = 1'b0;
    logic long_hold_done = 1'b0;

    ascii85_stream_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_char
        .s_tlast  (s_tlast),    // end_of_input
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] out_byte, [10:8] error_code, zero above
        .m_tuser  (m_tuser),    // [1:0] out_kind
        .m_tlast  (m_tlast),    // last
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow decoder
    // ------------------------------------------------------------------------

    function automatic logic [31:0] group_weight(input int pos);
        case (pos)
            0:       return W85_4;
            1:       return W85_3;
            2:       return W85_2;
            3:       return W85_1;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void emit(input logic [7:0] b, input kind_t k, input err_code_t e);
        decoded_t r;
        r.data = b;
        r.kind = k;
        r.code = e;
        r.last = 1'b0;
        decoded_due.push_back(r);
    endfunction

    function automatic void emit_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            emit(w[8*i +: 8], KIND_DATA, ERR_NONE);
    endfunction

    function automatic void clear_group();
        dec_count = 0;
        dec_acc = '0;
    endfunction

    function automatic void restart_decoder();
        dec_phase = PH_START;
        clear_group();
    endfunction

    // Flush a partial group, rounded up, then mark the stream finished
    function automatic void finish_stream();
        logic [31:0] w;
        if (dec_count > 0 && dec_count < 5)
        begin
            w = dec_acc + group_weight(dec_count - 1);
            for (int i = 1; i < dec_count; i++)
                emit(w[(4 - i) * 8 +: 8], KIND_DATA, ERR_NONE);
        end
        emit(8'h00, KIND_DONE, ERR_NONE);
        clear_group();
    endfunction

    function automatic void enter_drain(input err_code_t e);
        emit(8'h00, KIND_ERR, e);
        dec_phase = PH_DRAIN;
        clear_group();
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic eoi);
        int before_n;
        before_n = decoded_due.size();
        if (dec_phase == PH_DRAIN)
        begin
            if (eoi)
                restart_decoder();
            return;
        end
        if (!eoi && is_blank(c))
            return;
        if (dec_phase == PH_START && !cfg_require)
            dec_phase = PH_BODY;
        case (dec_phase)
            PH_START:
            begin
                if (eoi)
                begin
                    emit(8'h00, KIND_ERR, ERR_MISSING_LT);
                    restart_decoder();
                end
                else if (c == CH_LT)
                    dec_phase = PH_SAW_LT;
            end
            PH_SAW_LT:
            begin
                if (eoi)
                begin
                    emit(8'h00, KIND_ERR, ERR_MISSING_LT);
                    restart_decoder();
                end
                else if (c == CH_TILDE)
                    dec_phase = PH_BODY;
                else if (c != CH_LT)
                    dec_phase = PH_START;
            end
            PH_BODY:
            begin
                if (eoi)
                begin
                    if (cfg_require)
                        emit(8'h00, KIND_ERR, ERR_MISSING_GT);
                    else
                        finish_stream();
                    restart_decoder();
                end
                else if (c == CH_Z && dec_count == 0)
                    emit_word(32'h0);
                else if (c == CH_Y && dec_count == 0)
                    emit_word(SPACE_WORD);
                else if (c == CH_TILDE && cfg_require)
                    dec_phase = PH_SAW_TILDE;
                else if (c < CH_BANG || c > CH_U)
                begin
                    if (!cfg_ignore)
                        enter_drain(ERR_INVALID);
                end
                else
                begin
                    // Accumulate the digit; the sum wraps at 32 bits
                    dec_acc = dec_acc + 32'(c - CH_BANG) * group_weight(dec_count);
                    dec_count++;
                    if (dec_count == 5)
                    begin
                        emit_word(dec_acc);
                        clear_group();
                    end
                end
            end
            PH_SAW_TILDE:
            begin
                if (!eoi && c == CH_GT)
                begin
                    finish_stream();
                    dec_phase = PH_DRAIN;
                end
                else if (eoi)
                begin
                    emit(8'h00, KIND_ERR, ERR_TILDE_NO_GT);
                    restart_decoder();
                end
                else
                    enter_drain(ERR_TILDE_NO_GT);
            end
            default:
                restart_decoder();
        endcase
        if (decoded_due.size() > before_n)
            decoded_due[decoded_due.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Idle pattern: mostly short gaps, now and then a long one
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: predict on acceptance, then offer the next request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_char(s_tdata, s_tlast);
                accepted_count++;
            end
            if ($urandom_range(0, 99) == 0)
                tx_calm = !tx_calm;
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (char_queue.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= char_queue[0].ch;
                    s_tlast <= char_queue[0].eoi;
                    void'(char_queue.pop_front());
                    tx_gap = tx_calm ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output ready pattern, with one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (want_long_hold && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                rx_gap = LONG_HOLD_CYCLES;
            end
            if ($urandom_range(0, 99) == 0)
                rx_calm = !rx_calm;
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm)
                    rx_gap = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (decoded_due.size() == 0)
                report_mismatch($sformatf("unexpected result data %02h kind %0d code %0d",
                                          m_tdata[7:0], m_tuser, m_tdata[10:8]));
            else
            begin
                due_now = decoded_due.pop_front();
                if (due_now.kind == KIND_ERR)
                    errors_seen++;
                if (m_tdata[7:0] !== due_now.data || m_tdata[10:8] !== due_now.code ||
                    m_tuser !== due_now.kind || m_tlast !== due_now.last ||
                    m_tdata[15:11] !== '0)
                    report_mismatch($sformatf(
                        "got data %02h kind %0d code %0d last %0b pad %02h, want %02h %0d %0d %0b",
                        m_tdata[7:0], m_tuser, m_tdata[10:8], m_tlast, m_tdata[15:11],
                        due_now.data, due_now.kind, due_now.code, due_now.last));
            end
        end
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results still due",
                     cycle_count, decoded_due.size());
            $display("ascii85_stream_decoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_req(input logic [7:0] c, input logic eoi);
        char_req_t r;
        r.ch = c;
        r.eoi = eoi;
        char_queue.push_back(r);
        pushed_count++;
    endtask

    task automatic push_char(input logic [7:0] c);
        push_req(c, 1'b0);
    endtask

    // End of input carries a random, ignored character
    task automatic push_eoi();
        push_req(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(int'(CH_TAB) + r);
    endfunction

    // Digits lean towards the two extremes now and then
    function automatic logic [7:0] rand_digit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return CH_BANG;
        else if (r == 1)
            return CH_U;
        else
            return 8'($urandom_range(int'(CH_BANG), int'(CH_U)));
    endfunction

    function automatic logic [7:0] rand_invalid();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 8));
        else
            return 8'($urandom_range(int'(CH_U) + 1, 255));
    endfunction

    task automatic maybe_blank();
        if ($urandom_range(0, 7) == 0)
            push_char(rand_blank());
    endtask

    // One stream: mostly well formed, some broken, some pure noise
    task automatic push_stream();
        int sel;
        int groups;
        int partial;
        int tail;
        sel = $urandom_range(0, 99);
        if (sel < 12)
        begin
            repeat ($urandom_range(1, 8))
                push_char(8'($urandom_range(0, 255)));
            push_eoi();
            return;
        end
        if (cfg_require)
        begin
            repeat ($urandom_range(0, 2))
                push_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                push_char(CH_LT);
            push_char(CH_LT);
            maybe_blank();
            push_char(CH_TILDE);
        end
        groups = $urandom_range(0, 3);
        repeat (groups)
        begin
            maybe_blank();
            sel = $urandom_range(0, 5);
            if (sel == 0)
                push_char(CH_Z);
            else if (sel == 1)
                push_char(CH_Y);
            else
                repeat (5)
                begin
                    push_char(rand_digit());
                    maybe_blank();
                end
        end
        partial = $urandom_range(0, 4);
        repeat (partial)
            push_char(rand_digit());
        if ($urandom_range(0, 9) == 0)
            push_char(rand_invalid());
        if (cfg_require)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                push_eoi();
                return;
            end
            push_char(CH_TILDE);
            maybe_blank();
            if (sel < 15)
            begin
                push_eoi();
                return;
            end
            if (sel < 22)
                push_char(rand_digit());
            else
                push_char(CH_GT);
            tail = $urandom_range(0, 2);
            repeat (tail)
                push_char(8'($urandom_range(0, 255)));
        end
        push_eoi();
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {{(APB_DATA_W - 1){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_registers(input logic req, input logic ign);
        apb_write(ADDR_REQUIRE, req);
        apb_write(ADDR_IGNORE, ign);
        cfg_require = req;
        cfg_ignore = ign;
    endtask

    // Hold until all requests are taken and every result is back, then settle
    task automatic wait_drained();
        while (accepted_count != pushed_count || decoded_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [1:0] settings[4];
        int start_count;
        settings[0] = 2'b01;
        settings[1] = 2'b10;
        settings[2] = 2'b00;
        settings[3] = 2'b11;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: bare stream, invalid characters raise errors
        push_char(CH_Z);
        push_char(CH_Y);
        push_text("uuuuu");
        push_char(CH_BANG);
        push_eoi();
        push_char(CH_TILDE);
        push_eoi();
        push_text("9");
        push_char(CH_Z);
        push_eoi();
        wait_drained();

        // Delimited stream with invalid characters dropped
        set_registers(1'b1, 1'b1);
        push_text("x<a<<~9j");
        push_char(8'h80);
        push_text("~ >q");
        push_eoi();
        push_eoi();
        wait_drained();

        // Random streams under each register setting
        foreach (settings[i])
        begin
            set_registers(settings[i][1], settings[i][0]);
            if (i == 1)
                want_long_hold <= 1'b1;
            start_count = pushed_count;
            while (pushed_count - start_count < ITEMS_PER_SETTING)
                push_stream();
            wait_drained();
        end

        if (decoded_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decoded_due.size()));
        $display("Sent %0d character requests across all four register settings;",
                 accepted_count);
        $display("checked %0d results, %0d of them errors, in %0d cycles.",
                 results_seen, errors_seen, cycle_count);
        if (mismatches == 0)
            $display("ascii85_stream_decoder regression: pass");
        else
            $display("ascii85_stream_decoder regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/a85d_pkg.sv
rtl/ascii85_stream_decoder.sv
rtl/a85d_checker.sv
tb/ascii85_stream_decoder_tb.sv
